/* hw/rtl/salloc_pkg.sv */
// ----------------------------------------------------------------------------
// salloc_pkg
// Shared types and constants of the stack allocator with block headers.
// ----------------------------------------------------------------------------
package salloc_pkg;

    localparam int ADDR_W           = 32;
    localparam int SIZE_W           = 16;
    localparam int ALIGN_W          = 3;
    localparam int STATUS_W         = 3;
    localparam int OP_W             = 2;
    localparam int ADJ_W            = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_ALIGN_LOG2   = 6;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ZERO    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOROOM  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOTTOP  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] STS_FULL    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2 = 2'd2;

    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RESET = 3'd3;
    localparam logic [SIZE_W-1:0]  POOL_SIZE_RESET  = 16'hFFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd;
        logic commit_exec;
        logic commit_pop;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic needs_pop;
    } sts_t;

endpackage

/* hw/rtl/salloc_ram.sv */
// ----------------------------------------------------------------------------
// salloc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/salloc_ctrl.sv */
// ----------------------------------------------------------------------------
// salloc_ctrl
// Operation sequencer: capture, execute, and header pop for frees.
// ----------------------------------------------------------------------------
module salloc_ctrl
    import salloc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.needs_pop) begin
                    state_next = S_POP;
                end else if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_POP: begin
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: begin
                cmd.rd          = sts.needs_pop;
                cmd.commit_exec = !sts.needs_pop && !sts.out_busy;
            end
            S_POP: begin
                cmd.commit_pop = !sts.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/salloc_dp.sv */
// ----------------------------------------------------------------------------
// salloc_dp
// Datapath: configuration, allocator state, header stack and result register.
// ----------------------------------------------------------------------------
module salloc_dp
    import salloc_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int CNT_W        = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [SIZE_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]    s_free_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ADDR_W-1:0]    m_block_address,
    output logic [SIZE_W-1:0]    m_used_bytes,
    output logic [CNT_W-1:0]     m_live_blocks,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int AW    = $clog2(MAX_BLOCKS > 1 ? MAX_BLOCKS : 2);
    localparam int HDR_W = ADJ_W + ADDR_W;
    localparam int CALC_W = 9;
    localparam int SUM_W  = SIZE_W + 2;

    logic [ADDR_W-1:0]   base_reg;
    logic [SIZE_W-1:0]   psize_reg;
    logic [ALIGN_W-1:0]  alog_reg;
    logic [ADDR_W-1:0]   top_reg,    top_next;
    logic [ADDR_W-1:0]   newest_reg, newest_next;
    logic [SIZE_W-1:0]   used_reg,   used_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [OP_W-1:0]     op_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   faddr_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   baddr_reg,  baddr_next;
    logic [SIZE_W-1:0]   oused_reg;
    logic [CNT_W-1:0]    olive_reg;

    logic [ALIGN_W-1:0]  lg;
    logic [CALC_W-1:0]   align, mask, mis, adj0, need, rnd, adj;
    logic [SUM_W-1:0]    need_bytes;
    logic [ADDR_W-1:0]   alloc_addr;
    logic                cfg_base_wr;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [HDR_W-1:0]    ram_wdata, ram_rdata;
    logic [ADJ_W-1:0]    pop_adj;
    logic [ADDR_W-1:0]   pop_prev;
    logic [CNT_W-1:0]    count_dec;

    assign cfg_ready   = 1'b1;
    assign cfg_base_wr = cfg_valid && (cfg_index == REG_POOL_BASE);

    always_comb begin
        lg   = (alog_reg > ALIGN_W'(MAX_ALIGN_LOG2)) ? ALIGN_W'(MAX_ALIGN_LOG2) : alog_reg;
        align = CALC_W'(1) << lg;
        mask = align - CALC_W'(1);
        mis  = CALC_W'(top_reg[MAX_ALIGN_LOG2-1:0]) & mask;
        adj0 = (mis != '0) ? (align - mis) : '0;
        need = CALC_W'(HEADER_BYTES) - adj0;
        rnd  = ((need + mask) >> lg) << lg;
        adj  = (adj0 < CALC_W'(HEADER_BYTES)) ? (adj0 + rnd) : adj0;
        need_bytes = SUM_W'(used_reg) + SUM_W'(adj) + SUM_W'(size_reg);
        alloc_addr = top_reg + ADDR_W'(adj);
    end

    assign count_dec = count_reg - CNT_W'(1);
    assign pop_adj   = ram_rdata[HDR_W-1:ADDR_W];
    assign pop_prev  = ram_rdata[ADDR_W-1:0];

    assign sts.needs_pop = (op_reg == OP_FREE) && (count_reg != '0) &&
                           (faddr_reg == newest_reg);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    always_comb begin
        top_next    = top_reg;
        newest_next = newest_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        status_next = STS_OK;
        baddr_next  = '0;
        ram_we      = 1'b0;
        case (op_reg)
            OP_ALLOC: begin
                if (size_reg == '0) begin
                    status_next = STS_ZERO;
                end else if (count_reg >= CNT_W'(MAX_BLOCKS)) begin
                    status_next = STS_FULL;
                end else if (need_bytes > SUM_W'(psize_reg)) begin
                    status_next = STS_NOROOM;
                end else begin
                    ram_we      = cmd.commit_exec;
                    newest_next = alloc_addr;
                    top_next    = alloc_addr + ADDR_W'(size_reg);
                    used_next   = need_bytes[SIZE_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                    baddr_next  = alloc_addr;
                end
            end
            OP_FREE: begin
                if (count_reg == '0) begin
                    status_next = STS_EMPTY;
                end else if (faddr_reg != newest_reg) begin
                    status_next = STS_NOTTOP;
                end
            end
            OP_CLEAR: begin
                top_next    = base_reg;
                newest_next = base_reg;
                used_next   = '0;
                count_next  = '0;
            end
            default: begin
                status_next = STS_OK;
            end
        endcase
        if (cmd.commit_pop) begin
            newest_next = pop_prev;
            used_next   = used_reg - SIZE_W'(top_reg - faddr_reg) - SIZE_W'(pop_adj);
            top_next    = faddr_reg - ADDR_W'(pop_adj);
            count_next  = count_dec;
            status_next = STS_OK;
            baddr_next  = '0;
        end
    end

    assign ram_waddr = count_reg[AW-1:0];
    assign ram_raddr = count_dec[AW-1:0];
    assign ram_wdata = {adj[ADJ_W-1:0], newest_reg};

    salloc_ram #(
        .WIDTH (HDR_W),
        .DEPTH (MAX_BLOCKS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            psize_reg   <= POOL_SIZE_RESET;
            alog_reg    <= ALIGN_LOG2_RESET;
            top_reg     <= '0;
            newest_reg  <= '0;
            used_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_POOL_BASE:  base_reg  <= cfg_data;
                    REG_POOL_SIZE:  psize_reg <= cfg_data[SIZE_W-1:0];
                    REG_ALIGN_LOG2: alog_reg  <= cfg_data[ALIGN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cfg_base_wr) begin
                top_reg    <= cfg_data;
                newest_reg <= cfg_data;
                used_reg   <= '0;
                count_reg  <= '0;
            end else if (cmd.commit_exec || cmd.commit_pop) begin
                top_reg    <= top_next;
                newest_reg <= newest_next;
                used_reg   <= used_next;
                count_reg  <= count_next;
            end
            if (cmd.commit_exec || cmd.commit_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_operation;
            size_reg  <= s_request_size;
            faddr_reg <= s_free_address;
        end
        if (cmd.commit_exec || cmd.commit_pop) begin
            status_reg <= status_next;
            baddr_reg  <= baddr_next;
            oused_reg  <= used_next;
            olive_reg  <= count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_block_address = baddr_reg;
    assign m_used_bytes    = oused_reg;
    assign m_live_blocks   = olive_reg;

endmodule

/* hw/rtl/stack_allocator_with_headers.sv */
// ----------------------------------------------------------------------------
// stack_allocator_with_headers
// Last-in-first-out pool allocator that keeps a header per live block.
//
// Input channel s_*: one operation per transfer (allocate, free, clear).
// Result channel m_*: exactly one result per operation, in order.
// Configuration channel cfg_*: pool base, pool size, alignment; always ready.
// Writing the pool base also empties the allocator.
// Allocate, clear and failed frees are captured in the operation registers and
// then committed to the result register; a successful free adds a state for
// the registered read of the header stack RAM. One operation is in flight at
// a time: a new operation is not accepted until the last one has committed.
// A result waits in an output register; the next operation is accepted while
// it waits, and its commit is held until the receiver takes the earlier one.
// Reset empties the allocator, sets base 0, size 65535, alignment log2 3;
// the header stack needs no clearing since only pushed entries are read.
// ----------------------------------------------------------------------------
module stack_allocator_with_headers
    import salloc_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int CNT_W        = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [SIZE_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]    s_free_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ADDR_W-1:0]    m_block_address,
    output logic [SIZE_W-1:0]    m_used_bytes,
    output logic [CNT_W-1:0]     m_live_blocks,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    cmd_t cmd;
    sts_t sts;

    salloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    salloc_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .CNT_W        (CNT_W)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_operation     (s_operation),
        .s_request_size  (s_request_size),
        .s_free_address  (s_free_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_used_bytes    (m_used_bytes),
        .m_live_blocks   (m_live_blocks),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sts             (sts)
    );

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_live_blocks <= CNT_W'(MAX_BLOCKS)))
        else $error("live block count above stack depth");

    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_block_address != '0)) |-> (m_status == STS_OK))
        else $error("block address returned with failing status");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second operation accepted while one is in flight");

    a_one_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit_exec && cmd.commit_pop))
        else $error("two commits in one cycle");

endmodule
